>>> design/tsat_pkg.sv
package tsat_pkg;

    // Sizes of the tracker.
    localparam int NUM_CORES  = 4;
    localparam int EPOCH_BITS = 32;
    localparam int CORE_W     = $clog2(NUM_CORES);

    // Field widths of the item formats.
    localparam int CMD_W      = 2;
    localparam int ID_W       = 2;
    localparam int MASK_W     = 4;
    localparam int EPOCH_W    = 32;
    localparam int RETRY_W    = 5;
    localparam int SPIN_W     = 25;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 25;

    localparam logic [RETRY_W-1:0] RETRY_RESET = RETRY_W'(10);
    localparam logic [SPIN_W-1:0]  SPIN_RESET  = SPIN_W'(20000000);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LOG2 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPINS  = CFG_IDX_W'(1);

    // Commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_SYNC  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   core_id;
        logic [MASK_W-1:0] online_mask;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0]  poke_mask;
        logic [MASK_W-1:0]  quarantine_mask;
        logic               invalidate_local;
        logic               done_res;
        logic               gave_up;
        logic               rejected;
        logic [EPOCH_W-1:0] epoch_now;
    } t_out_item;

    typedef struct packed {
        logic [RETRY_W-1:0] retry_log2;
        logic [SPIN_W-1:0]  max_spins;
    } t_cfg;

endpackage

>>> design/tsat_cfg_regs.sv
module tsat_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tsat_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tsat_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output tsat_pkg::t_cfg                     o_cfg
);
    import tsat_pkg::*;

    logic [RETRY_W-1:0] r_retry_log2;
    logic [SPIN_W-1:0]  r_max_spins;

    // Writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Register file with its reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_log2 <= RETRY_RESET;
            r_max_spins  <= SPIN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RETRY_LOG2: r_retry_log2 <= i_cfg_data[RETRY_W-1:0];
                CFG_MAX_SPINS:  r_max_spins  <= i_cfg_data[SPIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.retry_log2 = r_retry_log2;
    assign o_cfg.max_spins  = r_max_spins;

endmodule

>>> design/tsat_in_stage.sv
module tsat_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tsat_pkg::t_in_item  i_item,
    input  logic                i_advance,
    output logic                o_held_valid,
    output tsat_pkg::t_in_item  o_held_item
);
    import tsat_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // The held item blocks a new one only when it cannot move on.
    assign o_stall = r_valid && !i_advance;

    // Valid flag of the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Payload of the input register.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

    assign o_held_valid = r_valid;
    assign o_held_item  = r_item;

endmodule

>>> design/tsat_engine.sv
module tsat_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  tsat_pkg::t_in_item  i_item,
    input  tsat_pkg::t_cfg      i_cfg,
    output tsat_pkg::t_out_item o_result
);
    import tsat_pkg::*;

    // Tracker state.
    logic [EPOCH_BITS-1:0] r_epoch;
    logic [EPOCH_BITS-1:0] r_acked_epoch [NUM_CORES];
    logic                  r_busy;
    logic [NUM_CORES-1:0]  r_wait_online;
    logic [CORE_W-1:0]     r_initiator;
    logic [SPIN_W-1:0]     r_spin_count;
    logic                  r_recovered;

    // Next values.
    logic [EPOCH_BITS-1:0] n_epoch;
    logic                  n_busy;
    logic [NUM_CORES-1:0]  n_wait_online;
    logic [CORE_W-1:0]     n_initiator;
    logic [SPIN_W-1:0]     n_spin_count;
    logic                  n_recovered;
    logic [NUM_CORES-1:0]  ack_wr;
    logic [EPOCH_BITS-1:0] ack_val;

    logic [CORE_W-1:0]     core;
    logic [NUM_CORES-1:0]  core_bit;
    logic [NUM_CORES-1:0]  init_bit;
    logic [NUM_CORES-1:0]  in_mask;
    logic [EPOCH_BITS-1:0] epoch_inc;
    logic [EPOCH_BITS-1:0] epoch_new;
    logic [NUM_CORES-1:0]  stale_cur;
    logic [NUM_CORES-1:0]  stale_new;
    logic [SPIN_W-1:0]     retry_mask;
    logic [NUM_CORES-1:0]  others;
    logic [NUM_CORES-1:0]  resampled;
    logic [NUM_CORES-1:0]  poke;
    logic [NUM_CORES-1:0]  quar;
    logic                  inval;
    logic                  done;
    logic                  gave;
    logic                  rej;

    // Decode of the item's core and mask; an out-of-range core maps to core 0.
    always_comb begin
        core     = (32'(i_item.core_id) < NUM_CORES) ? CORE_W'(i_item.core_id) : '0;
        core_bit = NUM_CORES'(1) << core;
        init_bit = NUM_CORES'(1) << r_initiator;
        in_mask  = NUM_CORES'(i_item.online_mask);
    end

    // Next epoch wraps and skips zero.
    always_comb begin
        epoch_inc = r_epoch + EPOCH_BITS'(1);
        epoch_new = (epoch_inc == '0) ? EPOCH_BITS'(1) : epoch_inc;
    end

    // Per-core staleness against the current and the next epoch.
    always_comb begin
        for (int c = 0; c < NUM_CORES; c++) begin
            stale_cur[c] = (r_acked_epoch[c] != r_epoch);
            stale_new[c] = (r_acked_epoch[c] != epoch_new) && !core_bit[c];
        end
    end

    // Low retry_log2 bits of the spin count select the re-poke ticks.
    always_comb begin
        for (int i = 0; i < SPIN_W; i++) begin
            retry_mask[i] = (RETRY_W'(i) < i_cfg.retry_log2);
        end
        others    = r_wait_online & ~init_bit;
        resampled = in_mask | init_bit;
    end

    // Command decode and next state.
    always_comb begin
        n_epoch       = r_epoch;
        n_busy        = r_busy;
        n_wait_online = r_wait_online;
        n_initiator   = r_initiator;
        n_spin_count  = r_spin_count;
        n_recovered   = r_recovered;
        ack_wr        = '0;
        ack_val       = r_epoch;
        poke          = '0;
        quar          = '0;
        inval         = 1'b0;
        done          = 1'b0;
        gave          = 1'b0;
        rej           = 1'b0;

        unique case (t_cmd'(i_item.cmd))
            CMD_START: begin
                if (r_busy) begin
                    rej = 1'b1;
                end else begin
                    n_epoch = epoch_new;
                    ack_wr  = core_bit;
                    ack_val = epoch_new;
                    inval   = 1'b1;
                    poke    = (in_mask | core_bit) & stale_new;
                    if (poke == '0) begin
                        done = 1'b1;
                    end else begin
                        n_busy        = 1'b1;
                        n_wait_online = in_mask | core_bit;
                        n_initiator   = core;
                        n_spin_count  = '0;
                        n_recovered   = 1'b0;
                    end
                end
            end
            CMD_SYNC: begin
                if (stale_cur[core]) begin
                    ack_wr = core_bit;
                    inval  = 1'b1;
                end
            end
            CMD_TICK: begin
                if (r_busy) begin
                    if ((r_wait_online & stale_cur) == '0) begin
                        n_busy = 1'b0;
                        done   = 1'b1;
                    end else begin
                        if ((r_spin_count & retry_mask) == '0) begin
                            poke = others & stale_cur;
                        end
                        if (r_spin_count >= i_cfg.max_spins) begin
                            // Quarantine the stragglers and re-read the online mask.
                            quar          = others & stale_cur;
                            ack_wr        = quar;
                            n_wait_online = resampled;
                            if (quar == '0 || r_recovered) begin
                                n_busy = 1'b0;
                                done   = 1'b1;
                                gave   = 1'b1;
                            end else begin
                                n_recovered  = 1'b1;
                                n_spin_count = '0;
                                poke = poke | (resampled & ~init_bit & stale_cur & ~quar);
                            end
                        end else begin
                            n_spin_count = r_spin_count + SPIN_W'(1);
                        end
                    end
                end
            end
            CMD_NOP: begin
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch       <= EPOCH_BITS'(1);
            r_busy        <= 1'b0;
            r_wait_online <= '0;
            r_initiator   <= '0;
            r_spin_count  <= '0;
            r_recovered   <= 1'b0;
        end else if (i_fire) begin
            r_epoch       <= n_epoch;
            r_busy        <= n_busy;
            r_wait_online <= n_wait_online;
            r_initiator   <= n_initiator;
            r_spin_count  <= n_spin_count;
            r_recovered   <= n_recovered;
        end
    end

    // Acknowledged epoch of each core.
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CORES; c++) begin
            if (!i_rst_n) begin
                r_acked_epoch[c] <= EPOCH_BITS'(1);
            end else if (i_fire && ack_wr[c]) begin
                r_acked_epoch[c] <= ack_val;
            end
        end
    end

    // Result fields.
    always_comb begin
        o_result.poke_mask        = MASK_W'(poke);
        o_result.quarantine_mask  = MASK_W'(quar);
        o_result.invalidate_local = inval;
        o_result.done_res         = done;
        o_result.gave_up          = gave;
        o_result.rejected         = rej;
        o_result.epoch_now        = EPOCH_W'(n_epoch);
    end

endmodule

>>> design/tlb_shootdown_ack_tracker.sv
// Accepted items pass the input register, then the result register.
// Throughput: one item per cycle; the engine settles an item combinationally between
// the input register and the result register, and stalls only on a full output.
// Reset (synchronous, active low) sets the epoch and every core's acked epoch to 1,
// leaves the tracker idle, empties both registers and loads retry_log2 10 and
// max_spins 20000000.
module tlb_shootdown_ack_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  tsat_pkg::t_in_item              i_item,
    output logic                            o_valid,
    input  logic                            i_stall,
    output tsat_pkg::t_out_item             o_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tsat_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tsat_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tsat_pkg::*;

    logic      advance;
    logic      held_valid;
    t_in_item  held_item;
    logic      fire;
    t_cfg      cfg;
    t_out_item result;
    logic      r_out_valid;
    t_out_item r_out_item;

    // The result register can take a new item when empty or being drained.
    assign advance = !r_out_valid || !i_stall;
    assign fire    = held_valid && advance;

    tsat_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tsat_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_item       (i_item),
        .i_advance    (advance),
        .o_held_valid (held_valid),
        .o_held_item  (held_item)
    );

    tsat_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (held_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= held_valid;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

>>> design/tsat_checker.sv
module tsat_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input tsat_pkg::t_out_item o_item
);
    import tsat_pkg::*;

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

    // The epoch never reads zero.
    a_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.epoch_now != '0)
        else $error("epoch is zero");

    // Giving up always finishes the shootdown.
    a_gave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.gave_up |-> o_item.done_res)
        else $error("gave up without finishing");

    // A rejected start has no other effect.
    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.rejected |-> o_item.poke_mask == '0 &&
            !o_item.invalidate_local && !o_item.done_res && o_item.quarantine_mask == '0)
        else $error("rejected item had effects");

    // A quarantine only comes from a tick.
    a_quar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.quarantine_mask != '0 |-> !o_item.invalidate_local &&
            !o_item.rejected)
        else $error("quarantine outside a tick");

endmodule

bind tlb_shootdown_ack_tracker tsat_checker u_tsat_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);
